/* rtl/skvt_pkg.sv */
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants for the small key/value table core.
// ----------------------------------------------------------------------------
package skvt_pkg;

   // Operation codes on req_kind
   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   // Fixed field widths
   localparam int unsigned KIND_BITS  = 2;
   localparam int unsigned COUNT_BITS = 7;
   localparam int unsigned OUT_BITS   = 32;

   // entries_in_use after reset
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 7'd64;

   // Controller states, one-hot
   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

/* rtl/small_key_value_table_core.sv */
// ----------------------------------------------------------------------------
// small_key_value_table_core
// Linear-probe key/value table held in two synchronous memories. Key 0 marks
// an empty slot. Lookup, insert and remove scan the slots one per cycle.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ---------------------------------
//  req      in         req_valid/req_stall  req_kind, req_key, req_value
//  rsp      out        rsp_valid/rsp_stall  rsp_success, rsp_result_value
//  csr      in         csr_valid/csr_ready  csr_entries_in_use
//
//  An operation reads slots until the answer is known (the first match, or
//  min(entries_in_use, SLOTS) slots when there is none); the key memory read
//  port reads one slot per cycle. Key 0, an unknown kind or entries_in_use of
//  0 skips the scan and goes straight to ST_DONE.
//  After reset the key memory is cleared one slot per cycle, with req_stall
//  high. csr writes are taken at any time (csr_ready is always high).
//  A finished result sits in the output register; the next request is taken
//  while it waits, and a further result waits in ST_DONE until rsp frees.
//
module small_key_value_table_core
   import skvt_pkg::*;
#(
   parameter int unsigned SLOTS      = 64,
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KIND_BITS-1:0]  req_kind,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [VALUE_BITS-1:0] req_value,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_success,
   output logic [OUT_BITS-1:0]   rsp_result_value,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COUNT_BITS-1:0] csr_entries_in_use
);

   localparam int unsigned IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CNT_BITS = $clog2(SLOTS + 1);
   localparam logic [31:0]          SLOTS_W  = 32'(SLOTS);
   localparam logic [IDX_BITS-1:0]  LAST_IDX = IDX_BITS'(SLOTS - 1);

   // Storage
   logic [KEY_BITS-1:0]   key_store   [SLOTS];
   logic [VALUE_BITS-1:0] value_store [SLOTS];

   // Control registers
   state_type             state_ff,     state_in;
   logic [IDX_BITS-1:0]   clr_cnt_ff,   clr_cnt_in;
   logic [COUNT_BITS-1:0] count_ff,     count_in;
   logic [CNT_BITS-1:0]   limit_ff,     limit_in;
   logic [CNT_BITS-1:0]   issue_cnt_ff, issue_cnt_in;
   logic                  rd_vld_ff,    rd_vld_in;
   logic                  rd_last_ff,   rd_last_in;
   logic                  free_vld_ff,  free_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [KIND_BITS-1:0]  kind_ff,      kind_in;
   logic [KEY_BITS-1:0]   key_ff,       key_in;
   logic [VALUE_BITS-1:0] value_ff,     value_in;
   logic [IDX_BITS-1:0]   rd_idx_ff,    rd_idx_in;
   logic [IDX_BITS-1:0]   free_idx_ff,  free_idx_in;
   logic                  res_ok_ff,    res_ok_in;
   logic [OUT_BITS-1:0]   res_val_ff,   res_val_in;
   logic                  rsp_ok_ff,    rsp_ok_in;
   logic [OUT_BITS-1:0]   rsp_val_ff,   rsp_val_in;
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] value_rd_ff;

   // Memory port controls
   logic                  key_we;
   logic                  value_we;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [KEY_BITS-1:0]   wr_key;
   logic [IDX_BITS-1:0]   rd_addr;

   logic                  req_take;
   logic                  rsp_free;
   logic                  rd_hit;
   logic                  rd_empty;
   logic [OUT_BITS-1:0]   rd_value_out;

   assign req_take     = req_valid && !req_stall;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rd_addr      = issue_cnt_ff[IDX_BITS-1:0];
   assign rd_hit       = rd_vld_ff && (key_rd_ff == key_ff);
   assign rd_empty     = key_rd_ff == '0;
   assign rd_value_out = OUT_BITS'(value_rd_ff);

   assign req_stall        = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_success      = rsp_ok_ff;
   assign rsp_result_value = rsp_val_ff;

   // Memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_store[wr_addr] <= wr_key;
      end
      if (value_we) begin
         value_store[wr_addr] <= value_ff;
      end
      key_rd_ff   <= key_store[rd_addr];
      value_rd_ff <= value_store[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_vld_in    = 1'b0;
      rd_last_in   = 1'b0;
      rd_idx_in    = rd_addr;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      res_ok_in    = res_ok_ff;
      res_val_in   = res_val_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_val_in   = rsp_val_ff;
      key_we       = 1'b0;
      value_we     = 1'b0;
      wr_addr      = rd_idx_ff;
      wr_key       = '0;

      if (csr_valid && csr_ready) begin
         count_in = csr_entries_in_use;
      end

      case (state_ff)
         ST_CLEAR: begin
            key_we     = 1'b1;
            wr_addr    = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_take) begin
               kind_in      = req_kind;
               key_in       = req_key;
               value_in     = req_value;
               issue_cnt_in = '0;
               free_vld_in  = 1'b0;
               res_ok_in    = 1'b0;
               res_val_in   = '0;
               // scan limit saturates at the table size
               if (32'(count_ff) > SLOTS_W) begin
                  limit_in = CNT_BITS'(SLOTS);
               end else begin
                  limit_in = CNT_BITS'(count_ff);
               end
               // reserved key, unknown kind or empty range: fail at once
               if (req_key == '0 || count_ff == '0 ||
                   !(req_kind == KIND_LOOKUP || req_kind == KIND_INSERT ||
                     req_kind == KIND_REMOVE)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // issue side
            if (issue_cnt_ff != limit_ff) begin
               issue_cnt_in = issue_cnt_ff + 1'b1;
               rd_vld_in    = 1'b1;
               rd_last_in   = (issue_cnt_ff == limit_ff - 1'b1);
            end
            // compare side, in the cycle after the read is issued
            if (rd_hit) begin
               state_in = ST_DONE;
               if (kind_ff != KIND_INSERT) begin
                  res_ok_in  = 1'b1;
                  res_val_in = rd_value_out;
               end
               if (kind_ff == KIND_REMOVE) begin
                  key_we  = 1'b1;
                  wr_addr = rd_idx_ff;
               end
            end else if (rd_vld_ff) begin
               if (rd_empty) begin
                  free_vld_in = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_last_ff) begin
                  state_in = ST_DONE;
                  if (kind_ff == KIND_INSERT && (free_vld_ff || rd_empty)) begin
                     key_we    = 1'b1;
                     value_we  = 1'b1;
                     wr_addr   = rd_empty ? rd_idx_ff : free_idx_ff;
                     wr_key    = key_ff;
                     res_ok_in = 1'b1;
                  end
               end
            end
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_val_in   = res_val_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         count_ff     <= COUNT_RESET;
         limit_ff     <= '0;
         issue_cnt_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         free_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rd_last_ff   <= rd_last_in;
         free_vld_ff  <= free_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      rd_idx_ff   <= rd_idx_in;
      free_idx_ff <= free_idx_in;
      res_ok_ff   <= res_ok_in;
      res_val_ff  <= res_val_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_val_ff  <= rsp_val_in;
   end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for small_key_value_table_core. A queue of table
// operations feeds a clocked request driver; a clocked response monitor
// checks each answer against an in-bench model of the slot table. The run
// steps through several entries_in_use settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench
   import skvt_pkg::*;
();

   localparam int unsigned SLOT_COUNT  = 64;
   localparam int unsigned KEY_W       = 32;
   localparam int unsigned VAL_W       = 32;
   localparam int unsigned KEY_POOL_N  = 48;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   // kind 3 has no operation behind it; the core must answer with a miss
   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      logic [KIND_BITS-1:0] kind;
      logic [KEY_W-1:0]     key;
      logic [VAL_W-1:0]     value;
      bit                   wait_drain;  // hold back until every answer is in
   } table_op_type;

   typedef struct {
      logic                success;
      logic [OUT_BITS-1:0] value;
   } table_answer_type;

   // ------------------------------------------------------------------------
   // DUT signals. Every input starts at a known value at time zero.
   // ------------------------------------------------------------------------
   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_stall;
   logic [KIND_BITS-1:0]  req_kind           = KIND_LOOKUP;
   logic [KEY_W-1:0]      req_key            = '0;
   logic [VAL_W-1:0]      req_value          = '0;
   logic                  rsp_valid;
   logic                  rsp_stall          = 1'b0;
   logic                  rsp_success;
   logic [OUT_BITS-1:0]   rsp_result_value;
   logic                  csr_valid          = 1'b0;
   logic                  csr_ready;
   logic [COUNT_BITS-1:0] csr_entries_in_use = COUNT_RESET;

   small_key_value_table_core #(
      .SLOTS      (SLOT_COUNT),
      .KEY_BITS   (KEY_W),
      .VALUE_BITS (VAL_W)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_key            (req_key),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_success        (rsp_success),
      .rsp_result_value   (rsp_result_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_entries_in_use (csr_entries_in_use)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Table model: key store, value store and the slot count register.
   // ------------------------------------------------------------------------
   logic [KEY_W-1:0]      table_keys   [SLOT_COUNT];
   logic [VAL_W-1:0]      table_values [SLOT_COUNT];
   logic [COUNT_BITS-1:0] table_count;

   table_op_type     pending_ops [$];   // filled by the sequencer, drained by the driver
   table_answer_type answer_q    [$];   // answers owed by the core, oldest first
   logic [KEY_W-1:0] key_pool [KEY_POOL_N];

   // Transfer counters. issued_n, accepted_n, checked_n and cycle_n are updated with
   // nonblocking assignments so every process sees the same pre-edge snapshot.
   int unsigned queued_n   = 0;   // written by the sequencer only, at negedge
   int unsigned issued_n   = 0;
   int unsigned accepted_n = 0;
   int unsigned checked_n  = 0;
   int unsigned error_n    = 0;
   int unsigned cycle_n    = 0;

   // Idle and stall odds in percent, changed only between phases
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   table_op_type cur_op;

   // Applies one operation to the table model and returns the answer.
   // Count above the slot total saturates; count zero scans nothing.
   function automatic void apply_op(input table_op_type op,
                                    output table_answer_type ans);
      int unsigned limit;
      int          free_slot;
      bit          present;
      ans.success = 1'b0;
      ans.value   = '0;
      limit       = (table_count > SLOT_COUNT) ? SLOT_COUNT : table_count;
      free_slot   = -1;
      present     = 1'b0;
      if (op.key != '0) begin
         case (op.kind)
            KIND_LOOKUP, KIND_REMOVE: begin
               // lowest matching slot wins; a hidden duplicate may sit above it
               for (int i = 0; i < limit; i++) begin
                  if (!ans.success && table_keys[i] == op.key) begin
                     ans.success = 1'b1;
                     ans.value   = table_values[i];
                     if (op.kind == KIND_REMOVE) table_keys[i] = '0;
                  end
               end
            end
            KIND_INSERT: begin
               // highest empty slot below the first match, if there is no match
               for (int i = 0; i < limit; i++) begin
                  if (table_keys[i] == op.key) present = 1'b1;
                  else if (!present && table_keys[i] == '0) free_slot = i;
               end
               if (!present && free_slot >= 0) begin
                  table_keys[free_slot]   = op.key;
                  table_values[free_slot] = op.value;
                  ans.success             = 1'b1;
               end
            end
            default: ;  // unused kind: no change, miss
         endcase
      end
   endfunction

   function automatic table_op_type random_op();
      table_op_type op;
      int unsigned  pick;
      pick = $urandom_range(99);
      if (pick < 35)      op.kind = KIND_INSERT;
      else if (pick < 65) op.kind = KIND_LOOKUP;
      else if (pick < 95) op.kind = KIND_REMOVE;
      else                op.kind = KIND_UNUSED;
      // mostly pool keys so lookups and removes hit, some reserved and fresh keys
      pick = $urandom_range(99);
      if (pick < 85)      op.key = key_pool[$urandom_range(KEY_POOL_N - 1)];
      else if (pick < 90) op.key = '0;
      else                op.key = $urandom;
      op.value      = $urandom;
      op.wait_drain = ($urandom_range(99) < 2);
      return op;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR: %s", msg);
      error_n++;
   endtask

   // ------------------------------------------------------------------------
   // Request driver. An operation enters the model at the edge where it
   // transfers, so the model order matches the core's order exactly.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      bit               fire;
      bit               go;
      table_answer_type ans;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && !req_stall;
         if (fire) begin
            apply_op(cur_op, ans);
            answer_q.push_back(ans);
            accepted_n <= accepted_n + 1;
         end
         if (!req_valid || fire) begin
            go = (pending_ops.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            // a drain-marked op waits until the core owes nothing
            if (go && pending_ops[0].wait_drain)
               go = !req_valid && (accepted_n == checked_n);
            if (go) begin
               cur_op = pending_ops.pop_front();
               req_kind  <= cur_op.kind;
               req_key   <= cur_op.key;
               req_value <= cur_op.value;
               req_valid <= 1'b1;
               issued_n  <= issued_n + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: field-by-field check against the oldest owed answer.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      table_answer_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               report_mismatch($sformatf("response with none outstanding: success %b value %h",
                                         rsp_success, rsp_result_value));
            end else begin
               want = answer_q.pop_front();
               checked_n <= checked_n + 1;
               if (rsp_success !== want.success)
                  report_mismatch($sformatf("response %0d success: got %b, want %b",
                                            checked_n, rsp_success, want.success));
               if (rsp_result_value !== want.value)
                  report_mismatch($sformatf("response %0d result_value: got %h, want %h",
                                            checked_n, rsp_result_value, want.value));
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
      if (cycle_n == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer helpers
   // ------------------------------------------------------------------------

   // Returns once every queued op has transferred and been answered.
   task automatic wait_idle();
      do @(posedge clock);
      while (issued_n != queued_n || req_valid || accepted_n != checked_n);
      repeat (4) @(posedge clock);
   endtask

   // Register write; only called while the core is idle.
   task automatic write_count(input logic [COUNT_BITS-1:0] n);
      @(posedge clock);
      csr_valid          <= 1'b1;
      csr_entries_in_use <= n;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid   <= 1'b0;
      table_count  = n;
   endtask

   // Called at negedge so the driver never races the push.
   task automatic queue_op(input logic [KIND_BITS-1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
      table_op_type op;
      op.kind       = kind;
      op.key        = key;
      op.value      = value;
      op.wait_drain = 1'b0;
      pending_ops.push_back(op);
      queued_n++;
   endtask

   task automatic run_phase(input logic [COUNT_BITS-1:0] count, input int unsigned idle_pct,
                            input int unsigned stall_pct, input int unsigned n);
      table_op_type op;
      write_count(count);
      @(negedge clock);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int unsigned i = 0; i < n; i++) begin
         op = random_op();
         // one guaranteed full drain per phase
         if (i == n / 2) op.wait_drain = 1'b1;
         pending_ops.push_back(op);
         queued_n++;
      end
      wait_idle();
   endtask

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         table_keys[i]   = '0;
         table_values[i] = '0;
      end
      table_count = COUNT_RESET;
      for (int i = 0; i < KEY_POOL_N; i++) begin
         key_pool[i] = $urandom;
         if (key_pool[i] == '0) key_pool[i] = 32'd1;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset count, no idling. The core spends its
      // first cycles clearing the key memory; the driver just waits.
      @(negedge clock);
      queue_op(KIND_LOOKUP, '0, '0);                         // reserved key
      queue_op(KIND_INSERT, '0, 32'hDEAD_BEEF);
      queue_op(KIND_REMOVE, '0, '0);
      queue_op(KIND_UNUSED, key_pool[0], 32'h1234_5678);     // unused kind
      queue_op(KIND_LOOKUP, key_pool[0], '0);                // miss on empty table
      queue_op(KIND_REMOVE, key_pool[0], '0);
      queue_op(KIND_INSERT, key_pool[0], '0);                // lands in top slot
      queue_op(KIND_INSERT, key_pool[0], 32'd1);             // duplicate
      queue_op(KIND_LOOKUP, key_pool[0], '0);
      queue_op(KIND_INSERT, '1, '1);                         // all-ones key and value
      queue_op(KIND_LOOKUP, '1, '0);
      queue_op(KIND_INSERT, 32'd1, 32'h5555_AAAA);
      queue_op(KIND_UNUSED, 32'd1, '0);                      // unused kind on a stored key
      queue_op(KIND_REMOVE, '1, '1);
      queue_op(KIND_LOOKUP, '1, '0);                         // gone
      queue_op(KIND_INSERT, '1, 32'h1234_5678);              // reuses the freed slot
      queue_op(KIND_REMOVE, 32'd1, '0);
      queue_op(KIND_REMOVE, 32'd1, '0);                      // already removed
      queue_op(KIND_LOOKUP, 32'h8000_0000, '0);
      queue_op(KIND_INSERT, 32'h8000_0000, 32'hAAAA_5555);
      queue_op(KIND_LOOKUP, 32'h8000_0000, '0);
      queue_op(KIND_LOOKUP, '1, '0);
      wait_idle();

      // Random phases: count, sender idle %, receiver stall %, ops
      run_phase(7'd127, 0, 0, 150);                    // saturates to all slots
      run_phase(7'd0, 61, 0, 30);                      // nothing scanned
      run_phase(7'd1, 0, 61, 60);                      // single slot, table full fast
      run_phase(7'd5, 37, 37, 120);                    // hidden keys above slot 4
      run_phase(7'd64, 61, 0, 150);
      run_phase(7'($urandom_range(2, 63)), 0, 61, 110);
      run_phase(7'd100, 37, 37, 100);

      repeat (80) @(posedge clock);
      if (error_n == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
